// ===== sv/sspr_pkg.sv =====
package sspr_pkg;

	localparam int FEAT_W     = 32;
	localparam int ACC_W      = 48;
	localparam int MODE_W     = 2;
	localparam int CHAN_CFG_W = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int CIDX_W     = 6;
	localparam int STEP_W     = 6;

	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;

	localparam logic [MODE_W-1:0] MODE_MAX = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SUM = 2'd1;
	localparam logic [MODE_W-1:0] MODE_AVG = 2'd2;

	localparam logic [MODE_W-1:0]     MODE_RESET     = MODE_MAX;
	localparam logic [CHAN_CFG_W-1:0] CHANNELS_RESET = 7'd16;

	// -2^31 held in the 48-bit accumulator format
	localparam logic signed [ACC_W-1:0] ACC_IDENT_MAX = 48'shFFFF_8000_0000;
	localparam logic signed [ACC_W-1:0] ACC_POS_LIM   = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [ACC_W-1:0] ACC_NEG_LIM   = 48'sh8000_0000_0000;
	localparam logic [STEP_W-1:0]       DIV_LAST      = STEP_W'(ACC_W - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_DADDR,
		S_DCALC,
		S_DDIV,
		S_DOUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic accum;
		logic rd_drain;
		logic calc;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic row_done;
		logic avg;
		logic div_done;
		logic out_free;
		logic drain_last;
	} status_t;

	function automatic logic signed [FEAT_W-1:0] sat_q32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = 48'sh0000_7FFF_FFFF;
		lo = ACC_IDENT_MAX;
		if (v > hi)
			return 32'sh7FFF_FFFF;
		else if (v < lo)
			return 32'sh8000_0000;
		else
			return v[FEAT_W-1:0];
	endfunction

endpackage

// ===== sv/sspr_ctrl.sv =====
module sspr_ctrl
	import sspr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_nx = S_ACC;
			end
			S_ACC: begin
				state_nx = status.row_done ? S_DADDR : S_IDLE;
			end
			S_DADDR: begin
				state_nx = S_DCALC;
			end
			S_DCALC: begin
				state_nx = status.avg ? S_DDIV : S_DOUT;
			end
			S_DDIV: begin
				if (status.div_done)
					state_nx = S_DOUT;
			end
			S_DOUT: begin
				if (status.out_free)
					state_nx = status.drain_last ? S_IDLE : S_DADDR;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_ACC: begin
				cmd.accum = 1'b1;
			end
			S_DADDR: begin
				cmd.rd_drain = 1'b1;
			end
			S_DCALC: begin
				cmd.calc = 1'b1;
			end
			S_DDIV: begin
				cmd.div_step = 1'b1;
			end
			S_DOUT: begin
				cmd.out_load = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== sv/sspr_datapath.sv =====
module sspr_datapath
	import sspr_pkg::*;
#(
	parameter int MAX_CHANNELS    = 16,
	parameter int EDGE_COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	output status_t                       status,
	input  logic signed [FEAT_W-1:0]      feat_elem,
	input  logic                          row_end,
	input  logic                          row_empty,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [CIDX_W-1:0]             channel_index,
	output logic signed [FEAT_W-1:0]      pool_result,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int EC_W  = EDGE_COUNT_BITS;

	logic [MODE_W-1:0]          mode_q;
	logic [CHAN_CFG_W-1:0]      chan_q;
	logic signed [FEAT_W-1:0]   feat_q;
	logic                       end_q;
	logic                       empty_q;
	logic [IDX_W-1:0]           pos_q;
	logic [EC_W-1:0]            edges_q;
	logic [IDX_W-1:0]           didx_q;
	logic [MAX_CHANNELS-1:0]    vld_q;
	logic signed [ACC_W-1:0]    mem [MAX_CHANNELS];
	logic signed [ACC_W-1:0]    rd_data_q;
	logic                       rd_vld_q;
	logic signed [ACC_W-1:0]    res_q;
	logic [ACC_W-1:0]           quo_q;
	logic [EC_W-1:0]            rem_q;
	logic                       neg_q;
	logic [STEP_W-1:0]          step_q;
	logic                       out_valid_q;
	logic [CIDX_W-1:0]          cidx_q;
	logic signed [FEAT_W-1:0]   pooled_q;
	logic                       last_q;

	logic [CHAN_CFG_W-1:0]      eff_ch;
	logic [IDX_W-1:0]           last_pos;
	logic [IDX_W-1:0]           rd_addr;
	logic signed [ACC_W-1:0]    ident;
	logic signed [ACC_W-1:0]    entry;
	logic signed [ACC_W-1:0]    feat_ext;
	logic signed [ACC_W:0]      sum_wide;
	logic signed [ACC_W-1:0]    sum_sat;
	logic signed [ACC_W-1:0]    acc_new;
	logic                       wrap;
	logic                       end_any;
	logic [IDX_W-1:0]           pos_after;
	logic                       bump;
	logic                       cfg_hit;
	logic                       row_clear;
	logic [EC_W-1:0]            divisor;
	logic [EC_W:0]              rem_sh;
	logic                       ge;
	logic [ACC_W-1:0]           quo_nx;
	logic                       drain_last;
	logic                       out_free;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == REG_MODE || cfg_index == REG_CHANNELS);

	always_comb begin
		if (chan_q > CHAN_CFG_W'(MAX_CHANNELS))
			eff_ch = CHAN_CFG_W'(MAX_CHANNELS);
		else if (chan_q == '0)
			eff_ch = CHAN_CFG_W'(1);
		else
			eff_ch = chan_q;
	end

	assign last_pos   = IDX_W'(eff_ch - CHAN_CFG_W'(1));
	assign rd_addr    = cmd.rd_drain ? didx_q : pos_q;
	assign ident      = (mode_q == MODE_MAX) ? ACC_IDENT_MAX : '0;
	assign entry      = rd_vld_q ? rd_data_q : ident;
	assign feat_ext   = ACC_W'(feat_q);
	assign sum_wide   = {entry[ACC_W-1], entry} + {feat_ext[ACC_W-1], feat_ext};

	always_comb begin
		if (sum_wide[ACC_W] != sum_wide[ACC_W-1])
			sum_sat = sum_wide[ACC_W] ? ACC_NEG_LIM : ACC_POS_LIM;
		else
			sum_sat = sum_wide[ACC_W-1:0];
		if (mode_q == MODE_MAX)
			acc_new = (feat_ext > entry) ? feat_ext : entry;
		else
			acc_new = sum_sat;
	end

	// a partial edge at row end still counts as one edge
	assign wrap      = pos_q == last_pos;
	assign end_any   = empty_q || end_q;
	assign pos_after = empty_q ? pos_q : (wrap ? '0 : pos_q + IDX_W'(1));
	assign bump      = (!empty_q && wrap) || (end_any && pos_after != '0);

	assign drain_last = didx_q == last_pos;
	assign out_free   = !out_valid_q || out_ready;
	assign row_clear  = cfg_hit || (cmd.out_load && drain_last);

	// restoring divider, one quotient bit per cycle
	assign divisor = (edges_q == '0) ? EC_W'(1) : edges_q;
	assign rem_sh  = {rem_q, quo_q[ACC_W-1]};
	assign ge      = rem_sh >= {1'b0, divisor};
	assign quo_nx  = {quo_q[ACC_W-2:0], ge};

	assign status.row_done   = end_any;
	assign status.avg        = mode_q == MODE_AVG;
	assign status.div_done   = step_q == DIV_LAST;
	assign status.out_free   = out_free;
	assign status.drain_last = drain_last;

	always_ff @(posedge clk) begin
		if (cmd.accum && !empty_q)
			mem[pos_q] <= acc_new;
		rd_data_q <= mem[rd_addr];
		rd_vld_q  <= vld_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_RESET;
			chan_q      <= CHANNELS_RESET;
			pos_q       <= '0;
			edges_q     <= '0;
			didx_q      <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE:     mode_q <= cfg_data[MODE_W-1:0];
					REG_CHANNELS: chan_q <= cfg_data;
					default:      ;
				endcase
			end
			if (cmd.accum) begin
				if (!empty_q)
					vld_q[pos_q] <= 1'b1;
				pos_q <= pos_after;
				if (bump && edges_q != '1)
					edges_q <= edges_q + EC_W'(1);
				didx_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				didx_q      <= didx_q + IDX_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (row_clear) begin
				vld_q   <= '0;
				pos_q   <= '0;
				edges_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			feat_q  <= feat_elem;
			end_q   <= row_end;
			empty_q <= row_empty;
		end
		if (cmd.calc) begin
			res_q  <= entry;
			quo_q  <= entry[ACC_W-1] ? ACC_W'(-entry) : entry;
			neg_q  <= entry[ACC_W-1];
			rem_q  <= '0;
			step_q <= '0;
		end
		if (cmd.div_step) begin
			quo_q  <= quo_nx;
			rem_q  <= ge ? EC_W'(rem_sh - {1'b0, divisor}) : rem_sh[EC_W-1:0];
			step_q <= step_q + STEP_W'(1);
			if (step_q == DIV_LAST)
				res_q <= neg_q ? ACC_W'(-quo_nx) : quo_nx;
		end
		if (cmd.out_load) begin
			cidx_q   <= CIDX_W'(didx_q);
			pooled_q <= sat_q32(res_q);
			last_q   <= drain_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign channel_index = cidx_q;
	assign pool_result   = pooled_q;
	assign last          = last_q;

endmodule

// ===== sv/sparse_segment_pool_reduce.sv =====
// An element's channel entry is read in the cycle it is taken, and it is folded into its channel in the next,
// so the input takes no new element until that fold is done (read, then read-modify-write).
// Row end: per channel the drain steps are read, select and load output for max and sum;
// average adds the 48-bit restoring divider between select and load output.
// Output stalls hold the drain. Reset clears the FSM, row state and accumulator
// valid bits at once; registers return to max mode with 16 channels.
module sparse_segment_pool_reduce
	import sspr_pkg::*;
#(
	parameter int MAX_CHANNELS    = 16,
	parameter int EDGE_COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [FEAT_W-1:0]      feat_elem,
	input  logic                          row_end,
	input  logic                          row_empty,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [CIDX_W-1:0]             channel_index,
	output logic signed [FEAT_W-1:0]      pool_result,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	cmd_t    cmd;
	status_t status;

	sspr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	sspr_datapath #(
		.MAX_CHANNELS    (MAX_CHANNELS),
		.EDGE_COUNT_BITS (EDGE_COUNT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.feat_elem     (feat_elem),
		.row_end       (row_end),
		.row_empty     (row_empty),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.channel_index (channel_index),
		.pool_result   (pool_result),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

`ifndef SYNTHESIS
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again during accumulate cycle");

	a_empty_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && row_empty) |-> ##2 !in_ready)
		else $error("empty row did not start a drain");

	a_mid_row_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> !in_ready)
		else $error("input open while row drain unfinished");
`endif

endmodule
